// ===== design/pfdc_pkg.sv =====
// Shared types, constants and codes of the packet FIFO with duplicate filter.
package pfdc_pkg;

  // Storage geometry.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  // Field widths.
  localparam int CAP_W   = 7;
  localparam int OP_W    = 2;
  localparam int ADDR_FW = 20;
  localparam int TIME_W  = 31;
  localparam int CNT_W   = 7;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_FORWARD = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT   = 2'd2;

  // One input transaction.
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [ADDR_FW-1:0] source;
    logic [ADDR_FW-1:0] destination;
    logic [TIME_W-1:0]  timestamp;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic               accepted;
    logic               found;
    logic [ADDR_FW-1:0] out_source;
    logic [ADDR_FW-1:0] out_destination;
    logic [TIME_W-1:0]  out_timestamp;
    logic [CNT_W-1:0]   match_count;
  } result_t;

  // One stored packet.
  typedef struct packed {
    logic [ADDR_FW-1:0] source;
    logic [ADDR_FW-1:0] destination;
    logic [TIME_W-1:0]  timestamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ===== design/pfdc_ctrl.sv =====
// Controller state machine: sequences the load, scan and commit phases.
module pfdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pfdc_pkg::status_t status,
  output pfdc_pkg::cmd_t    cmd,
  output logic             busy
);
  import pfdc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== design/pfdc_datapath.sv =====
// Datapath: packet store, ring pointers, scan counter, matchers and result register.
module pfdc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  pfdc_pkg::cmd_t               cmd,
  input  pfdc_pkg::item_t              item,
  input  logic                         capacity_we,
  input  logic [pfdc_pkg::CAP_W-1:0]   capacity_data,
  output pfdc_pkg::status_t            status,
  output pfdc_pkg::result_t            result,
  output logic                         done
);
  import pfdc_pkg::*;

  // Packet store, one write and one registered read port.
  entry_t mem [DEPTH];
  entry_t rd_data;

  // Control state.
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [OCC_W-1:0]  occupancy;
  logic [CAP_W-1:0]  capacity;
  logic [ADDR_W-1:0] rd_ptr;
  logic [OCC_W-1:0]  idx;
  logic [OCC_W-1:0]  limit;
  logic              rd_valid;

  // Operand and accumulators of the current transaction.
  item_t             op;
  logic              dup;
  logic [OCC_W-1:0]  count;

  logic              issue;
  logic              full_match;
  logic              range_match;
  logic [OCC_W-1:0]  eff_cap;
  logic              at_cap;
  logic              write_en;
  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] tail_next;
  logic [OCC_W-1:0]  occupancy_next;
  logic [OCC_W-1:0]  limit_next;
  result_t           result_next;

  // Ring increment with wrap at the store depth.
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ADDR_W'(1);
    end
    return r;
  endfunction

  // A read is issued while entries remain to be visited.
  assign issue = cmd.step && (idx != limit);
  assign status.scan_done = (idx == limit) && !rd_valid;

  // Comparators on the entry read in the previous cycle.
  assign full_match  = rd_valid && (rd_data.source == op.source) &&
                       (rd_data.destination == op.destination) &&
                       (rd_data.timestamp == op.timestamp);
  assign range_match = rd_valid && (rd_data.destination == op.destination) &&
                       (rd_data.timestamp >= op.start_time) &&
                       (rd_data.timestamp <= op.end_time);

  // Capacity clamped into the range one to the store depth.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = OCC_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      eff_cap = OCC_W'(DEPTH);
    end else begin
      eff_cap = OCC_W'(capacity);
    end
  end
  assign at_cap = (occupancy >= eff_cap);

  // Number of entries to visit for the incoming transaction.
  always_comb begin
    unique case (item.opcode)
      OP_ADD, OP_COUNT: limit_next = occupancy;
      OP_FORWARD:       limit_next = (occupancy != '0) ? OCC_W'(1) : '0;
      default:          limit_next = '0;
    endcase
  end

  // Pointer and occupancy update and result of the commit phase.
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    write_en       = 1'b0;
    result_next    = '0;
    unique case (op.opcode)
      OP_ADD: begin
        if (!dup) begin
          write_en             = 1'b1;
          tail_next            = ptr_inc(tail);
          result_next.accepted = 1'b1;
          if (at_cap) begin
            // Oldest entry is dropped, so the fill level stays put.
            head_next = ptr_inc(head);
          end else begin
            occupancy_next = occupancy + OCC_W'(1);
          end
        end
      end
      OP_FORWARD: begin
        if (occupancy != '0) begin
          result_next.found           = 1'b1;
          result_next.out_source      = rd_data.source;
          result_next.out_destination = rd_data.destination;
          result_next.out_timestamp   = rd_data.timestamp;
          head_next                   = ptr_inc(head);
          occupancy_next              = occupancy - OCC_W'(1);
        end
      end
      OP_COUNT: begin
        result_next.match_count = CNT_W'(count);
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      capacity  <= CAP_RESET;
      idx       <= '0;
      limit     <= '0;
      rd_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (capacity_we) begin
        capacity <= capacity_data;
      end
      if (cmd.load) begin
        idx      <= '0;
        limit    <= limit_next;
        rd_valid <= 1'b0;
      end else if (cmd.step) begin
        rd_valid <= issue;
        if (issue) begin
          idx <= idx + OCC_W'(1);
        end
      end else begin
        rd_valid <= 1'b0;
      end
      if (cmd.commit) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
      end
    end
  end

  // Operand, scan address, accumulators and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= item;
      rd_ptr <= head;
      dup    <= 1'b0;
      count  <= '0;
    end else if (cmd.step) begin
      if (issue) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (full_match) begin
        dup <= 1'b1;
      end
      if (range_match) begin
        count <= count + OCC_W'(1);
      end
    end
    if (cmd.commit) begin
      result <= result_next;
    end
  end

  // Store read port.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (write_en && cmd.commit) begin
      mem[tail] <= '{source: op.source, destination: op.destination,
                     timestamp: op.timestamp};
    end
  end

endmodule

// ===== design/packet_fifo_dedup_count.sv =====
// Top level of the bounded packet FIFO with duplicate filter and range counter.
//
// A transaction is offered on item with start; it is taken at a clock edge
// where start is high and busy is low. Opcode add stores a packet unless an
// identical one is held, dropping the oldest when at capacity; forward pops
// the oldest packet; count returns how many held packets match a destination
// with a timestamp in an inclusive range; the spare code gives an all-zero
// result. Every transaction gives exactly one result on result, marked by
// done for a single cycle; the receiver cannot stall it.
// After the accepting edge the scan phase reads every held entry (only the
// oldest for a forward, none when the FIFO is empty or for the spare code),
// then the commit phase updates the store and the result register, from
// which done is registered; the held entries are read one per cycle through
// the single registered read port of the store. A new transaction may be
// offered in the cycle where done is shown. The capacity register is written
// with capacity_we and capacity_data; the user must write it only while idle,
// which the block does not enforce. 0 acts as 1 and values above 64 act as
// 64. Reset empties the FIFO, sets capacity to 64 and leaves busy and done low.
module packet_fifo_dedup_count (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  pfdc_pkg::item_t             item,
  output logic                        busy,
  input  logic                        capacity_we,
  input  logic [pfdc_pkg::CAP_W-1:0]  capacity_data,
  output logic                        done,
  output pfdc_pkg::result_t           result
);
  import pfdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller.
  pfdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath.
  pfdc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item          (item),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .status        (status),
    .result        (result),
    .done          (done)
  );

  // A result is only shown once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // Each transaction gives a single one-cycle result.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // Commands to the datapath never overlap.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("overlapping datapath commands");

endmodule
